[rtl/afb_pkg.sv]
// Shared types, constants and helper functions for the ASCII frame builder.
package afb_pkg;

   // Frame layout, by byte position
   localparam int POS_W = 5;
   localparam logic [POS_W-1:0] POS_START  = 5'd0;
   localparam logic [POS_W-1:0] POS_VER_HI = 5'd1;
   localparam logic [POS_W-1:0] POS_VER_LO = 5'd2;
   localparam logic [POS_W-1:0] POS_SRC    = 5'd3;
   localparam logic [POS_W-1:0] POS_DST    = 5'd6;
   localparam logic [POS_W-1:0] POS_NET    = 5'd9;
   localparam logic [POS_W-1:0] POS_CH     = 5'd12;
   localparam logic [POS_W-1:0] POS_PAD    = 5'd14;
   localparam logic [POS_W-1:0] POS_TAG    = 5'd15;
   localparam logic [POS_W-1:0] POS_SUM    = 5'd21;
   localparam logic [POS_W-1:0] POS_END    = 5'd24;

   localparam int TAG_LEN = 6;
   localparam logic [2:0] TAG_COUNT = 3'd6;

   // Fixed characters
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_ONE  = 8'h31;
   localparam logic [7:0] CHAR_HASH = 8'h23;

   // Checksum handling
   localparam int SUM_W = 11;
   localparam logic [SUM_W-1:0] SUM_LIMIT = 11'd999;
   localparam int SUM_SHIFT = 4;
   localparam logic [6:0] CHANNEL_MAX = 7'd99;

   // Register indexes
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_BYTE    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OWN_ADDR      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEST_ADDR     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_NET_ID        = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_RADIO_CHANNEL = 3'd4;

   localparam int QUEUE_DEPTH = 2;

   // Classified command handed from front to back
   typedef struct packed {
      logic       header_only;
      logic [2:0] tag_sel;
   } cmd_type;

   // Configuration seen by the back end
   typedef struct packed {
      logic [7:0] start_byte;
      logic [7:0] own_addr;
      logic [7:0] dest_addr;
      logic [7:0] net_id;
      logic [6:0] radio_channel;
   } cfg_type;

   // Split a value below 1000 into hundreds, tens and ones digits
   function automatic logic [11:0] to_bcd3(input logic [9:0] v);
      logic [3:0] h;
      logic [3:0] t;
      logic [9:0] r;
      logic [9:0] o;
      h = '0;
      for (int k = 1; k <= 9; k++) begin
         if (v >= 10'(k * 100)) h = 4'(k);
      end
      r = v - 10'(h * 100);
      t = '0;
      for (int k = 1; k <= 9; k++) begin
         if (r >= 10'(k * 10)) t = 4'(k);
      end
      o = r - 10'(t * 10);
      return {h, t, o[3:0]};
   endfunction

   // One character of the tag chosen by message type
   function automatic logic [7:0] tag_char(input logic [2:0] sel, input logic [2:0] idx);
      logic [47:0] tag;
      case (sel)
         3'd0:    tag = "[INN1]";
         3'd1:    tag = "[INN2]";
         3'd2:    tag = "[INN3]";
         3'd3:    tag = "[SENO]";
         3'd4:    tag = "[SESI]";
         3'd5:    tag = "[ALAM]";
         default: tag = '0;
      endcase
      return tag[8 * (TAG_LEN - 1 - int'(idx)) +: 8];
   endfunction

endpackage

[rtl/afb_front.sv]
// Front end: accepts requests and classifies them into commands.
module afb_front
   import afb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [2:0] req_message_type,
   input  logic       queue_full,
   output logic       busy,
   output logic       push,
   output cmd_type    push_cmd
);

   logic    push_ff;
   cmd_type cmd_ff;

   // Hold off new requests while the queue has no room or an accepted request is still being pushed
   assign busy = queue_full | push_ff;

   // Register the accepted item with its class
   always_ff @(posedge clock) begin
      if (reset) begin
         push_ff <= 1'b0;
      end else begin
         push_ff <= start & ~busy;
      end
      if (start & ~busy) begin
         cmd_ff.header_only <= (req_message_type >= TAG_COUNT);
         cmd_ff.tag_sel     <= req_message_type;
      end
   end

   assign push     = push_ff;
   assign push_cmd = cmd_ff;

endmodule

[rtl/afb_queue.sv]
// Short command queue between front and back end.
module afb_queue
   import afb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    full,
   output logic    not_empty,
   output cmd_type head_cmd
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   cmd_type             mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff;
   logic [PTR_W-1:0]    rd_ptr_ff;
   logic [PTR_W:0]      count_ff;
   logic [PTR_W:0]      count_in;

   assign full      = (count_ff >= (PTR_W+1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_cmd  = mem_ff[rd_ptr_ff];

   // Track occupancy
   always_comb begin
      count_in = count_ff;
      if (push && !(pop && not_empty)) count_in = count_ff + 1'b1;
      if (!push && pop && not_empty)   count_in = count_ff - 1'b1;
   end

   // Advance pointers and store entries
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop && not_empty) rd_ptr_ff <= rd_ptr_ff + 1'b1;
      end
      if (push) mem_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule

[rtl/afb_back.sv]
// Back end: sequences frame bytes and builds the running checksum.
module afb_back
   import afb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       cmd_valid,
   input  cmd_type    cmd,
   output logic       pop,
   output logic       rsp_strobe,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_byte
);

   logic             active_ff;
   logic             active_in;
   logic [POS_W-1:0] pos_ff;
   logic [POS_W-1:0] pos_in;
   cmd_type          cmd_ff;
   logic [SUM_W-1:0] sum_ff;
   logic [SUM_W-1:0] sum_in;
   logic             strobe_ff;
   logic [7:0]       byte_ff;
   logic             last_ff;

   logic             at_last;
   logic [POS_W-1:0] last_pos;
   logic [6:0]       channel;
   logic [9:0]       checksum;
   logic [9:0]       conv_val;
   logic [POS_W-1:0] conv_base;
   logic [POS_W-1:0] digit_off;
   logic [11:0]      bcd;
   logic [3:0]       digit;
   logic [7:0]       byte_sel;

   // Find the final byte of the current frame
   assign last_pos = cmd_ff.header_only ? POS_PAD : POS_END;
   assign at_last  = active_ff && (pos_ff == last_pos);
   assign pop      = cmd_valid && (!active_ff || at_last);

   // Saturate channel, fold an oversized checksum
   assign channel  = (cfg.radio_channel > CHANNEL_MAX) ? CHANNEL_MAX : cfg.radio_channel;
   assign checksum = (sum_ff > SUM_LIMIT) ? 10'(sum_ff >> SUM_SHIFT) : 10'(sum_ff);

   // Pick the number printed at this position and its first digit slot
   always_comb begin
      conv_val  = '0;
      conv_base = POS_START;
      if (pos_ff >= POS_SUM) begin
         conv_val  = checksum;
         conv_base = POS_SUM;
      end else if (pos_ff >= POS_CH) begin
         conv_val  = 10'(channel);
         conv_base = POS_CH - 1'b1;
      end else if (pos_ff >= POS_NET) begin
         conv_val  = 10'(cfg.net_id);
         conv_base = POS_NET;
      end else if (pos_ff >= POS_DST) begin
         conv_val  = 10'(cfg.dest_addr);
         conv_base = POS_DST;
      end else if (pos_ff >= POS_SRC) begin
         conv_val  = 10'(cfg.own_addr);
         conv_base = POS_SRC;
      end
      bcd       = to_bcd3(conv_val);
      digit_off = pos_ff - conv_base;
      case (digit_off)
         5'd0:    digit = bcd[11:8];
         5'd1:    digit = bcd[7:4];
         default: digit = bcd[3:0];
      endcase
   end

   // Select the byte for this position
   always_comb begin
      case (pos_ff) inside
         POS_START:                           byte_sel = cfg.start_byte;
         POS_VER_HI:                          byte_sel = CHAR_ONE;
         POS_VER_LO, POS_PAD:                 byte_sel = CHAR_ZERO;
         [POS_SRC:POS_PAD-1], [POS_SUM:POS_END-1]:
                                              byte_sel = CHAR_ZERO + 8'(digit);
         [POS_TAG:POS_SUM-1]:
            byte_sel = tag_char(cmd_ff.tag_sel, 3'(pos_ff - POS_TAG));
         POS_END:                             byte_sel = CHAR_HASH;
         default:                             byte_sel = '0;
      endcase
   end

   // Advance the sequencer, start the next frame right after the last byte
   always_comb begin
      active_in = active_ff;
      pos_in    = pos_ff;
      sum_in    = sum_ff;
      if (active_ff && pos_ff < POS_SUM) sum_in = sum_ff + SUM_W'(byte_sel);
      if (pop) begin
         active_in = 1'b1;
         pos_in    = POS_START;
         sum_in    = '0;
      end else if (at_last) begin
         active_in = 1'b0;
      end else if (active_ff) begin
         pos_in = pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         strobe_ff <= active_ff;
      end
      pos_ff  <= pos_in;
      sum_ff  <= sum_in;
      byte_ff <= byte_sel;
      last_ff <= at_last;
      if (pop) cmd_ff <= cmd;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_out_byte  = byte_ff;
   assign rsp_last_byte = last_ff;

endmodule

[rtl/ascii_frame_builder_with_checksum.sv]
// Top level of the ASCII frame builder: registers, front, queue and back end.
// The first byte of a frame passes the front-end push register, the queue, the sequencer and the output register.
// A full frame is 25 bytes and a header-only frame 15 bytes, sent one byte a
// cycle from the back-end sequencer; frames follow each other without a gap while the queue holds the next one.
// A new request is held off while the previous one is pushed or the two-entry queue is full.
// Synchronous reset restores the register defaults; results are never stalled.
module ascii_frame_builder_with_checksum
   import afb_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [2:0]             req_message_type,
   output logic                   rsp_strobe,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_last_byte,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_data
);

   cfg_type cfg_ff;
   logic    push;
   cmd_type push_cmd;
   logic    queue_full;
   logic    queue_not_empty;
   cmd_type head_cmd;
   logic    pop;

   assign csr_ready = 1'b1;

   // Write configuration registers, drop writes beyond the list
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_byte    <= 8'd42;
         cfg_ff.own_addr      <= 8'd10;
         cfg_ff.dest_addr     <= 8'd1;
         cfg_ff.net_id        <= 8'd1;
         cfg_ff.radio_channel <= 7'd11;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_START_BYTE:    cfg_ff.start_byte    <= csr_data;
            CSR_OWN_ADDR:      cfg_ff.own_addr      <= csr_data;
            CSR_DEST_ADDR:     cfg_ff.dest_addr     <= csr_data;
            CSR_NET_ID:        cfg_ff.net_id        <= csr_data;
            CSR_RADIO_CHANNEL: cfg_ff.radio_channel <= csr_data[6:0];
            default:           ;
         endcase
      end
   end

   afb_front u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .req_message_type (req_message_type),
      .queue_full       (queue_full),
      .busy             (busy),
      .push             (push),
      .push_cmd         (push_cmd)
   );

   afb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head_cmd  (head_cmd)
   );

   afb_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .cmd_valid     (queue_not_empty),
      .cmd           (head_cmd),
      .pop           (pop),
      .rsp_strobe    (rsp_strobe),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last_byte (rsp_last_byte)
   );

endmodule
